// ----- sv/cwa_pkg.sv -----
package cwa_pkg;

   localparam int MAX_RADIUS_DEF  = 31;
   localparam int SAMPLE_BITS_DEF = 17;
   localparam int RADIUS_BITS     = 5;

   // Handshake status of the divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } cwa_div_status_type;

endpackage

// ----- sv/centered_window_average.sv -----
// Centered moving average over a stream of non-negative samples.
// Requests arrive on the req_ channel: one sample in req_tdata, with req_tlast
// set on the final sample of a run. For every sample position the block
// returns on the rsp_ channel the truncated mean of the 2k+1 samples around
// it, or all ones (minus one) where the window runs past either end of the
// run. The radius k is written through csr_wr_en / csr_wr_data while idle;
// any write also starts a new run. Results lag the input by k positions, and
// the final request flushes the trailing minus-one results, the last of which
// carries rsp_tlast.
// One request is handled at a time. A request first reads the sample ring, then,
// if a full window mean is due, passes through the bit-serial divider (one step
// per bit of the running sum, then the quotient is handed over), and then its
// results are delivered in turn; a stalled receiver simply holds rsp_tvalid and
// the request side stays closed until every result has been taken.
// Reset clears the run state and the radius; the ring memory is not cleared,
// since its data is only used once the window is full of samples of the current run.
module centered_window_average #(
   parameter int MAX_RADIUS  = cwa_pkg::MAX_RADIUS_DEF,
   parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + 8) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata fields from bit 0 up: sample
   input  logic [REQ_W-1:0]                req_tdata,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata fields from bit 0 up: average (signed)
   output logic [RSP_W-1:0]                rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [cwa_pkg::RADIUS_BITS-1:0] csr_wr_data
);

   import cwa_pkg::*;

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = SAMPLE_BITS + POS_W;
   localparam int AVG_W = SAMPLE_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_SEND
   } state_type;

   state_type              state_ff, state_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       seen_ff, seen_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   fin_ff, fin_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [AVG_W-1:0]       rsp_avg_ff, rsp_avg_in;

   logic [CNT_W-1:0]       k;
   logic [CNT_W-1:0]       w;
   logic [CNT_W-1:0]       seen_next;
   logic [SUM_W-1:0]       sum_next;
   logic                   full;
   logic                   has_main;
   logic                   accept;
   logic [POS_W:0]         old_addr;
   logic [SAMPLE_BITS-1:0] ring_rd_data;
   logic                   ring_wr_en;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   cwa_div_status_type     div_status;

   // Live radius saturates at the largest window the ring holds.
   always_comb begin
      if (32'(radius_ff) > MAX_RADIUS) begin
         k = CNT_W'(MAX_RADIUS);
      end else begin
         k = CNT_W'(radius_ff);
      end
      w = CNT_W'({k, 1'b1});
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign full       = (seen_ff >= w);
   assign seen_next  = full ? seen_ff : seen_ff + 1'b1;
   assign has_main   = ({1'b0, seen_next} >= ({1'b0, k} + 1'b1));
   assign ring_wr_en = (state_ff == ST_READ);

   // Ring data for the oldest slot is valid in the read cycle; one subtract, one add.
   // The divider takes this sum even when the final sample clears the run state.
   assign sum_next = sum_ff - (full ? SUM_W'(ring_rd_data) : SUM_W'(0))
                   + SUM_W'(sample_ff);

   // The oldest sample of the window sits w slots behind the write slot.
   always_comb begin
      if ({1'b0, pos_ff} >= (POS_W + 1)'(w)) begin
         old_addr = {1'b0, pos_ff} - (POS_W + 1)'(w);
      end else begin
         old_addr = {1'b0, pos_ff} + (POS_W + 1)'(DEPTH) - (POS_W + 1)'(w);
      end
   end

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      fin_in       = fin_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_avg_in   = rsp_avg_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               fin_in    = req_tlast;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            sum_in  = sum_next;
            seen_in = seen_next;
            pos_in  = (32'(pos_ff) == DEPTH - 1) ? '0 : pos_ff + 1'b1;
            if (has_main) begin
               left_in = fin_ff ? k + 1'b1 : CNT_W'(1);
            end else begin
               left_in = fin_ff ? seen_next : '0;
            end
            rsp_avg_in  = '1;
            rsp_last_in = fin_ff && (left_in == CNT_W'(1));
            if (left_in == '0) begin
               state_in = ST_IDLE;
            end else if (has_main && (seen_next >= w)) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_SEND;
            end
            if (fin_ff) begin
               sum_in  = '0;
               seen_in = '0;
               pos_in  = '0;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               rsp_avg_in   = {1'b0, quotient[SAMPLE_BITS-1:0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (left_ff == CNT_W'(1)) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // Every result after the first is an incomplete window.
                  left_in     = left_ff - 1'b1;
                  rsp_avg_in  = '1;
                  rsp_last_in = fin_ff && (left_ff == CNT_W'(2));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A radius write starts a fresh run; the user must write it only while idle, the block does not enforce this.
      if (csr_wr_en) begin
         radius_in = csr_wr_data;
         sum_in    = '0;
         seen_in   = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      fin_ff      <= fin_in;
      rsp_last_ff <= rsp_last_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   cwa_ring #(
      .DEPTH  (DEPTH),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (POS_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (old_addr[POS_W-1:0]),
      .rd_data (ring_rd_data)
   );

   cwa_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (w),
      .quotient (quotient),
      .status   (div_status)
   );

   assign rsp_tdata  = RSP_W'(rsp_avg_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- sv/cwa_ring.sv -----
module cwa_ring #(
   parameter int DEPTH  = 63,
   parameter int WIDTH  = 17,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cwa_div.sv -----
module cwa_div #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [NUM_W-1:0]                dividend,
   input  logic [DEN_W-1:0]                divisor,
   output logic [NUM_W-1:0]                quotient,
   output cwa_pkg::cwa_div_status_type     status
);

   import cwa_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;

   // Restoring division, one quotient bit per cycle from the top down.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- dv/centered_window_average_test.sv -----
`timescale 1ns / 1ps

module centered_window_average_test;

   localparam int MAX_K      = cwa_pkg::MAX_RADIUS_DEF;
   localparam int SMP_BITS   = cwa_pkg::SAMPLE_BITS_DEF;
   localparam int AVG_BITS   = SMP_BITS + 1;
   localparam int RING_SLOTS = 2 * MAX_K + 1;
   localparam int REQ_W      = ((SMP_BITS + 7) / 8) * 8;
   localparam int RSP_W      = ((SMP_BITS + 8) / 8) * 8;
   localparam logic [SMP_BITS-1:0] SAMPLE_MAX = '1;
   localparam logic [AVG_BITS-1:0] NO_MEAN    = '1;   // minus one: incomplete window
   // Worst single request: sender gap, ring read, divide, then up to 32 results
   // each behind a receiver stall. Taken several times.
   localparam int STALL_LIMIT = 2000;
   // Idle cycles allowed after the last result before a radius write or the end.
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [AVG_BITS-1:0] average;
      logic                end_of_run;
   } window_result_t;

   logic                       clock;
   logic                       reset;
   logic [REQ_W-1:0]           req_tdata;
   logic                       req_tlast;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [RSP_W-1:0]           rsp_tdata;
   logic                       rsp_tlast;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic                       csr_wr_en;
   logic [cwa_pkg::RADIUS_BITS-1:0] csr_wr_data;

   // Predictor state: a copy of the window ring, the running sum, the
   // saturating sample count and the next ring slot, plus the radius.
   logic [SMP_BITS-1:0]            mean_ring [RING_SLOTS];
   logic [22:0]                    mean_sum;
   logic [5:0]                     mean_count;
   logic [5:0]                     mean_slot;
   logic [cwa_pkg::RADIUS_BITS-1:0] mean_radius;

   window_result_t expected_means[$];
   int unsigned    fail_count;
   int unsigned    idle_cycles;
   int unsigned    send_gap_max;
   int unsigned    take_gap_max;

   centered_window_average DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void clear_window_run();
      mean_sum   = '0;
      mean_count = '0;
      mean_slot  = '0;
   endfunction

   // Works out the results one accepted sample causes and queues them.
   function automatic void predict_window_means(input logic [SMP_BITS-1:0] sample,
                                                input logic final_sample);
      int unsigned    k;
      int unsigned    w;
      int unsigned    old_slot;
      int unsigned    trailing;
      int unsigned    produced;
      window_result_t res;
      k = (mean_radius > MAX_K) ? MAX_K : mean_radius;
      w = 2 * k + 1;
      produced = 0;
      if (mean_count >= w) begin
         old_slot = (mean_slot + RING_SLOTS - w) % RING_SLOTS;
         mean_sum = mean_sum - mean_ring[old_slot];
      end
      mean_ring[mean_slot] = sample;
      mean_sum  = mean_sum + sample;
      mean_slot = 6'((mean_slot + 1) % RING_SLOTS);
      if (mean_count < w)
         mean_count = mean_count + 6'd1;
      if (mean_count >= k + 1) begin
         if (mean_count >= w)
            res.average = AVG_BITS'(int'(mean_sum) / int'(w));
         else
            res.average = NO_MEAN;
         res.end_of_run = 1'b0;
         expected_means.push_back(res);
         produced++;
      end
      if (final_sample) begin
         // The final sample flushes the trailing incomplete positions.
         trailing = (mean_count >= k + 1) ? k : mean_count;
         res.average    = NO_MEAN;
         res.end_of_run = 1'b0;
         repeat (trailing) begin
            expected_means.push_back(res);
            produced++;
         end
         if (produced > 0)
            expected_means[expected_means.size() - 1].end_of_run = 1'b1;
         clear_window_run();
      end
   endfunction

   // Sends one request after a random gap and predicts it once it is taken.
   task automatic send_sample(input logic [SMP_BITS-1:0] sample, input logic final_sample);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_W'(sample);
      req_tlast  <= final_sample;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_window_means(sample, final_sample);
   endtask

   // Holds requests back until every expected result has been taken.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_means.size() != 0);
   endtask

   task automatic set_radius(input int unsigned k);
      wait_for_drain();
      // A request that causes no result may still be in the ring read.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cwa_pkg::RADIUS_BITS'(k);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mean_radius = cwa_pkg::RADIUS_BITS'(k);
      clear_window_run();
   endtask

   function automatic logic [SMP_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return SAMPLE_MAX;
         default: return SMP_BITS'($urandom_range(0, int'(SAMPLE_MAX)));
      endcase
   endfunction

   // Radius zero right after reset: each sample comes back unchanged.
   task automatic test_reset_passthrough();
      send_sample('0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(17'h15555, 1'b0);
      send_sample(17'h0AAAA, 1'b1);
   endtask

   // Runs no longer than the window give minus one at every position but the centre of a full one.
   task automatic test_short_runs();
      set_radius(1);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample('0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   // A full window of the largest samples, then a zero to pull the mean down.
   task automatic test_full_window_extremes();
      set_radius(2);
      repeat (5) send_sample(SAMPLE_MAX, 1'b0);
      send_sample('0, 1'b1);
   endtask

   // A radius write in the middle of a run drops the rest of that run.
   task automatic test_radius_write_mid_run();
      set_radius(3);
      repeat (4) send_sample(pick_sample(), 1'b0);
      set_radius(MAX_K);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample('0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   // The sender stops mid-run until all results are out, then goes on.
   task automatic test_pause_mid_run();
      set_radius(4);
      send_gap_max = 2;
      take_gap_max = 8;
      for (int i = 0; i < 12; i++) begin
         if (i == 6)
            wait_for_drain();
         send_sample(pick_sample(), i == 11);
      end
   endtask

   task automatic run_random_phase(input int unsigned k, input int unsigned items);
      int unsigned sent;
      int unsigned run_len;
      int unsigned w;
      set_radius(k);
      w = 2 * k + 1;
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 9))
            0:       run_len = 1;
            1:       run_len = $urandom_range(1, w);
            default: run_len = $urandom_range(w, w + 24);
         endcase
         // A run cut off at the end of the phase is dropped by the next radius write.
         for (int i = 0; i < run_len && sent < items; i++) begin
            if ($urandom_range(0, 39) == 0)
               wait_for_drain();
            send_sample(pick_sample(), i == run_len - 1);
            sent++;
         end
      end
   endtask

   // The fixed phases give the widest radius long runs; the drawn ones stay short.
   task automatic test_random_runs();
      int unsigned radii[12];
      radii = '{0, MAX_K, 1, 2, MAX_K, 0, 0, 0, 0, 0, 0, 0};
      for (int i = 6; i < 12; i++)
         radii[i] = $urandom_range(0, MAX_K);
      foreach (radii[i])
         run_random_phase(radii[i], (i < 6 && radii[i] >= 20) ? 100 : 24);
   endtask

   // Receiver: draws a stall for every result, then waits for it.
   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = $urandom_range(0, take_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result checker: every taken result against the oldest expectation.
   always @(posedge clock) begin
      window_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_means.size() == 0) begin
            $error("unexpected result: average %0d end_of_run %0b",
                   $signed(rsp_tdata[AVG_BITS-1:0]), rsp_tlast);
            fail_count++;
         end else begin
            want = expected_means.pop_front();
            if (rsp_tdata[AVG_BITS-1:0] !== want.average) begin
               $error("average: expected %0d, actual %0d",
                      $signed(want.average), $signed(rsp_tdata[AVG_BITS-1:0]));
               fail_count++;
            end
            if (rsp_tlast !== want.end_of_run) begin
               $error("end_of_run: expected %0b, actual %0b", want.end_of_run, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      req_tvalid   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      fail_count   = 0;
      send_gap_max = 8;
      take_gap_max = 8;
      mean_radius  = '0;
      foreach (mean_ring[i])
         mean_ring[i] = '0;
      clear_window_run();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_passthrough();
      test_short_runs();
      test_full_window_extremes();
      test_radius_write_mid_run();
      test_pause_mid_run();
      test_random_runs();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_means.size() != 0) begin
         $error("%0d expected results never arrived", expected_means.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
